/* rtl/core/annexb_pkg.sv */
// Shared types, constants and NAL header helpers for the Annex-B access unit splitter.
// Used by annexb_front, annexb_fifo and annexb_access_unit_splitter; no dependencies.
`default_nettype none

package annexb_pkg;

	// byte positions saturate at 2^OFFSET_BITS - 1
	localparam int OFFSET_BITS = 32;
	localparam int STEP_BITS   = 20;
	localparam int TS_BITS     = 64;
	localparam int FIELD_BITS  = 32;

	// result queue; depth must be a power of two
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef logic [OFFSET_BITS-1:0] pos_t;
	localparam pos_t POS_MAX = '1;

	// configuration register indexes
	localparam logic CFG_CODEC    = 1'b0;
	localparam logic CFG_PTS_STEP = 1'b1;

	localparam logic [STEP_BITS-1:0] PTS_STEP_RESET = 20'd33333;

	localparam logic [7:0] BYTE_ONE = 8'h01;
	localparam logic [7:0] BYTE_ZERO = 8'h00;

	typedef struct packed {
		logic [FIELD_BITS-1:0] offset;
		logic [FIELD_BITS-1:0] size;
		logic                  key;
		logic [TS_BITS-1:0]    ts;
		logic                  fin;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic logic hdr_vcl(logic h265, logic [7:0] h);
		logic [4:0] t4;
		t4 = h[4:0];
		if (h265) begin
			return (h[6] == 1'b0);  // type 0..31
		end
		return t4 inside {[5'd1:5'd5]};
	endfunction

	function automatic logic hdr_key(logic h265, logic [7:0] h);
		logic [5:0] t5;
		t5 = h[6:1];
		if (h265) begin
			return t5 inside {[6'd16:6'd23]};
		end
		return (h[4:0] == 5'd5);
	endfunction

	function automatic pos_t sat_inc(pos_t v);
		return (v == POS_MAX) ? v : v + pos_t'(1);
	endfunction

	function automatic pos_t sub_floor(pos_t a, pos_t b);
		return (a >= b) ? a - b : '0;
	endfunction

	function automatic logic [FIELD_BITS-1:0] to_field(pos_t p);
		logic [63:0] w;
		w = 64'(p);
		return w[FIELD_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/annexb_front.sv */
// Front end: start code detection, NAL judging and access unit bookkeeping, one byte a cycle
// while room2 holds. Pushes zero to two results per byte to the queue. Depends on annexb_pkg.
`default_nettype none

module annexb_front (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_valid,
	input  wire                                cfg_index,
	input  wire [annexb_pkg::STEP_BITS-1:0]    cfg_data,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire [7:0]                          in_byte,
	input  wire                                in_eos,
	input  wire                                room2,
	output annexb_pkg::push_t                  push
);

	logic                             codec_q;
	logic [annexb_pkg::STEP_BITS-1:0] step_q;

	logic [1:0]                     zr_q;
	annexb_pkg::pos_t               pos_q;
	logic                           open_q;
	annexb_pkg::pos_t               coff_q;
	annexb_pkg::pos_t               dstart_q;
	logic [7:0]                     hdr_q;
	annexb_pkg::pos_t               ustart_q;
	logic                           has_vcl_q;
	logic                           is_key_q;
	logic [annexb_pkg::TS_BITS-1:0] pts_q;

	logic                           acc;
	logic [7:0]                     hdr;
	logic                           is_code;
	annexb_pkg::pos_t               back;
	annexb_pkg::pos_t               code;
	annexb_pkg::pos_t               pos_inc;
	annexb_pkg::pos_t               end_pos;
	logic                           vcl;
	logic                           key;
	logic                           emit;
	logic                           flush;
	logic                           has_vcl1;
	logic                           is_key1;
	annexb_pkg::pos_t               ustart1;
	logic [annexb_pkg::TS_BITS-1:0] pts1;
	annexb_pkg::res_t               r_close;
	annexb_pkg::res_t               r_flush;

	assign in_ready = room2;
	assign acc      = in_valid && in_ready;

	always_comb begin
		hdr     = (open_q && pos_q == dstart_q) ? in_byte : hdr_q;
		is_code = (in_byte == annexb_pkg::BYTE_ONE) && (zr_q >= 2'd2)
			&& (zr_q == 2'd3 || !in_eos);
		back    = (zr_q == 2'd3) ? annexb_pkg::pos_t'(3) : annexb_pkg::pos_t'(2);
		code    = annexb_pkg::sub_floor(pos_q, back);
		pos_inc = annexb_pkg::sat_inc(pos_q);
		// a NAL ends either at a new start code or at the final byte
		end_pos = is_code ? code : pos_inc;
		vcl     = open_q && (is_code || in_eos) && (end_pos > dstart_q)
			&& annexb_pkg::hdr_vcl(codec_q, hdr);
		key     = annexb_pkg::hdr_key(codec_q, hdr);
		emit    = vcl && has_vcl_q;

		has_vcl1 = has_vcl_q | vcl;
		is_key1  = emit ? key : (is_key_q | (vcl & key));
		ustart1  = emit ? coff_q : ustart_q;
		if (is_code && !open_q) begin
			ustart1 = code;
		end
		pts1  = emit ? pts_q + annexb_pkg::TS_BITS'(step_q) : pts_q;
		flush = in_eos && has_vcl1;

		r_close.offset = annexb_pkg::to_field(ustart_q);
		r_close.size   = annexb_pkg::to_field(annexb_pkg::sub_floor(coff_q, ustart_q));
		r_close.key    = is_key_q;
		r_close.ts     = pts_q;
		r_close.fin    = 1'b0;

		r_flush.offset = annexb_pkg::to_field(ustart1);
		r_flush.size   = annexb_pkg::to_field(annexb_pkg::sub_floor(pos_inc, ustart1));
		r_flush.key    = is_key1;
		r_flush.ts     = pts1;
		r_flush.fin    = 1'b1;

		push.cnt = acc ? (2'(emit) + 2'(flush)) : 2'd0;
		push.r0  = emit ? r_close : r_flush;
		push.r1  = r_flush;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_q <= 1'b0;
			step_q  <= annexb_pkg::PTS_STEP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				annexb_pkg::CFG_CODEC:    codec_q <= cfg_data[0];
				annexb_pkg::CFG_PTS_STEP: step_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zr_q      <= 2'd0;
			pos_q     <= '0;
			open_q    <= 1'b0;
			coff_q    <= '0;
			dstart_q  <= '0;
			hdr_q     <= '0;
			ustart_q  <= '0;
			has_vcl_q <= 1'b0;
			is_key_q  <= 1'b0;
			pts_q     <= '0;
		end else if (acc) begin
			if (in_eos) begin
				// stream ends: back to the reset picture, configuration registers keep their values
				zr_q      <= 2'd0;
				pos_q     <= '0;
				open_q    <= 1'b0;
				coff_q    <= '0;
				dstart_q  <= '0;
				hdr_q     <= '0;
				ustart_q  <= '0;
				has_vcl_q <= 1'b0;
				is_key_q  <= 1'b0;
				pts_q     <= '0;
			end else begin
				pos_q     <= pos_inc;
				hdr_q     <= hdr;
				zr_q      <= (in_byte != annexb_pkg::BYTE_ZERO) ? 2'd0
					: (zr_q == 2'd3) ? 2'd3 : zr_q + 2'd1;
				has_vcl_q <= has_vcl1;
				is_key_q  <= is_key1;
				ustart_q  <= ustart1;
				pts_q     <= pts1;
				if (is_code) begin
					open_q   <= 1'b1;
					coff_q   <= code;
					dstart_q <= pos_inc;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_eos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_eos |=> pos_q == '0 && !open_q && pts_q == '0)
		else $error("stream state not cleared after final byte");
	a_two_results: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd2 |-> push.r1.fin && !push.r0.fin && in_eos)
		else $error("second result of a byte must be the final flush");
	a_nal_order: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> dstart_q > coff_q)
		else $error("NAL payload start not after its start code");
`endif

endmodule

`default_nettype wire

/* rtl/core/annexb_fifo.sv */
// Result queue between the front end and the output channel; takes up to two items a cycle.
// Head entry drives the output channel directly. Depends on annexb_pkg.
`default_nettype none

module annexb_fifo (
	input  wire                clk,
	input  wire                arst_n,
	input  annexb_pkg::push_t  push,
	output logic               room2,
	output logic               out_valid,
	input  wire                out_ready,
	output annexb_pkg::res_t   out_res
);

	annexb_pkg::res_t                 mem_q [annexb_pkg::FIFO_DEPTH];
	logic [annexb_pkg::FIFO_AW-1:0]   wr_q;
	logic [annexb_pkg::FIFO_AW-1:0]   rd_q;
	logic [annexb_pkg::FIFO_CW-1:0]   count_q;
	logic                             pop;
	logic [annexb_pkg::FIFO_AW-1:0]   wr_next;

	assign out_valid = (count_q != '0);
	assign out_res   = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign room2     = (count_q <= annexb_pkg::FIFO_CW'(annexb_pkg::FIFO_DEPTH - 2));
	assign wr_next   = wr_q + annexb_pkg::FIFO_AW'(1);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + annexb_pkg::FIFO_AW'(push.cnt);
			rd_q    <= rd_q + annexb_pkg::FIFO_AW'(pop);
			count_q <= count_q + annexb_pkg::FIFO_CW'(push.cnt)
				- annexb_pkg::FIFO_CW'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd0 |-> room2)
		else $error("push into result queue without room for two items");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= annexb_pkg::FIFO_CW'(annexb_pkg::FIFO_DEPTH))
		else $error("result queue count out of range");
`endif

endmodule

`default_nettype wire

/* rtl/core/annexb_access_unit_splitter.sv */
// Annex-B access unit splitter: a byte stream in, one item per access unit out.
// Top level; instantiates annexb_front and annexb_fifo, uses annexb_pkg.
//
// s_axis carries one stream byte per item; tlast marks the final byte of a stream.
// m_axis carries one item per access unit: offset and size of the unit, its
// timestamp, a key flag in tuser, and tlast on the end-of-stream flush item.
// cfg takes register writes (index 0: codec select, 1: timestamp step in us);
// cfg_ready is always high, and writes belong between streams.
// Throughput: one byte per cycle while s_axis_tready is high. Each byte closes
// at most one unit and, if final, flushes the last one: zero to two items.
// Latency: an item caused by a byte is on m_axis the cycle after that byte is
// taken when no earlier item waits; otherwise it queues behind those items.
// Items wait in a four-entry queue; s_axis_tready drops while fewer than two
// entries are free, so a stalled receiver stops input once three or four items
// wait, and nothing is lost.
// Reset clears all stream state and the queue at once and restores the register
// defaults (H.264, 33333 us); no clearing pass follows. A final byte returns the
// stream state to reset, and the next byte starts at offset 0 and timestamp 0.
`default_nettype none

module annexb_access_unit_splitter (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire [7:0]                          s_axis_tdata,   // [7:0] data_byte
	input  wire                                s_axis_tlast,   // end_of_stream
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	// [31:0] unit_offset, [63:32] unit_size, [127:64] timestamp_us
	output logic [127:0]                       m_axis_tdata,
	output logic                               m_axis_tuser,   // [0] key_unit
	output logic                               m_axis_tlast,   // final_unit
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire                                cfg_index,
	input  wire [annexb_pkg::STEP_BITS-1:0]    cfg_data
);

	annexb_pkg::push_t push;
	annexb_pkg::res_t  head;
	logic              room2;

	assign cfg_ready = 1'b1;

	annexb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_eos    (s_axis_tlast),
		.room2     (room2),
		.push      (push)
	);

	annexb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (head)
	);

	assign m_axis_tdata = {head.ts, head.size, head.offset};
	assign m_axis_tuser = head.key;
	assign m_axis_tlast = head.fin;

endmodule

`default_nettype wire

/* tb/sv/annexb_access_unit_splitter_tb.sv */
// Testbench for annexb_access_unit_splitter: Annex-B byte streams in, access unit items out.
// Checks every item against a scoreboard that predicts units from the accepted bytes.
// Depends on annexb_pkg and the annexb_access_unit_splitter RTL.

module annexb_access_unit_splitter_tb;

	localparam bit [63:0] POS_LIMIT = (64'd1 << annexb_pkg::OFFSET_BITS) - 64'd1;
	localparam bit [4:0] H264_TYPE_MASK = 5'h1F;
	localparam int H264_VCL_FIRST  = 1;
	localparam int H264_IDR        = 5;
	localparam int H265_IRAP_FIRST = 16;
	localparam int H265_IRAP_LAST  = 23;
	localparam int H265_VCL_LAST   = 31;
	localparam int RANDOM_BYTES    = 1450;
	localparam int PHASE_BYTES     = 160;

	typedef struct packed {
		bit [31:0] unit_offset;
		bit [31:0] unit_size;
		bit        key_unit;
		bit [63:0] timestamp_us;
		bit        final_unit;
	} au_item_t;

	class au_scoreboard;
		bit                             codec_h265;
		bit [annexb_pkg::STEP_BITS-1:0] step_us;
		bit [1:0]                       zero_cnt;
		bit [63:0]                      pos, code_pos, payload_pos, au_start, pts;
		bit                             nal_active, au_vcl, au_key;
		bit [7:0]                       nal_hdr;
		au_item_t                       pending_units[$];
		int                             errors;

		function new();
			codec_h265 = 1'b0;
			step_us = annexb_pkg::PTS_STEP_RESET;
			errors = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			zero_cnt = 2'd0;
			pos = 64'd0;
			code_pos = 64'd0;
			payload_pos = 64'd0;
			au_start = 64'd0;
			pts = 64'd0;
			nal_active = 1'b0;
			au_vcl = 1'b0;
			au_key = 1'b0;
			nal_hdr = 8'd0;
		endfunction

		function void set_reg(bit idx, bit [annexb_pkg::STEP_BITS-1:0] v);
			if (idx == annexb_pkg::CFG_CODEC) begin
				codec_h265 = v[0];
			end else begin
				step_us = v;
			end
		endfunction

		function bit [63:0] bump(bit [63:0] v);
			return (v >= POS_LIMIT) ? POS_LIMIT : v + 64'd1;
		endfunction

		function bit hdr_is_vcl(bit [7:0] h);
			if (codec_h265) begin
				return int'(h[6:1]) <= H265_VCL_LAST;
			end
			return int'(h & H264_TYPE_MASK) >= H264_VCL_FIRST
				&& int'(h & H264_TYPE_MASK) <= H264_IDR;
		endfunction

		function bit hdr_is_key(bit [7:0] h);
			if (codec_h265) begin
				return int'(h[6:1]) >= H265_IRAP_FIRST && int'(h[6:1]) <= H265_IRAP_LAST;
			end
			return int'(h & H264_TYPE_MASK) == H264_IDR;
		endfunction

		function void push_unit(bit [63:0] off, bit [63:0] len, bit key, bit fin);
			au_item_t u;
			u.unit_offset = off[31:0];
			u.unit_size = len[31:0];
			u.key_unit = key;
			u.timestamp_us = pts;
			u.final_unit = fin;
			pending_units.push_back(u);
		endfunction

		// judge the open NAL whose payload ends before stop_pos
		function void close_nal(bit [63:0] stop_pos);
			bit vcl;
			vcl = (stop_pos > payload_pos) && hdr_is_vcl(nal_hdr);
			if (vcl && au_vcl) begin
				push_unit(au_start, (code_pos >= au_start) ? code_pos - au_start : 64'd0,
					au_key, 1'b0);
				pts = pts + 64'(step_us);
				au_start = code_pos;
				au_key = 1'b0;
				au_vcl = 1'b0;
			end
			if (vcl) begin
				au_vcl = 1'b1;
				if (hdr_is_key(nal_hdr)) begin
					au_key = 1'b1;
				end
			end
		endfunction

		function void note_byte(bit [7:0] b, bit eos);
			bit [63:0] p, back, code, stop_pos;
			p = pos;
			if (nal_active && p == payload_pos) begin
				nal_hdr = b;
			end
			// a 3-byte code ending on the final byte does not count
			if (b == annexb_pkg::BYTE_ONE && zero_cnt >= 2'd2
				&& (zero_cnt == 2'd3 || !eos)) begin
				back = (zero_cnt == 2'd3) ? 64'd3 : 64'd2;
				code = (p >= back) ? p - back : 64'd0;
				if (nal_active) begin
					close_nal(code);
				end else begin
					au_start = code;
				end
				nal_active = 1'b1;
				code_pos = code;
				payload_pos = bump(p);
			end
			if (b == annexb_pkg::BYTE_ZERO) begin
				zero_cnt = (zero_cnt == 2'd3) ? 2'd3 : zero_cnt + 2'd1;
			end else begin
				zero_cnt = 2'd0;
			end
			if (eos) begin
				stop_pos = bump(p);
				if (nal_active) begin
					close_nal(stop_pos);
				end
				if (au_vcl) begin
					push_unit(au_start, (stop_pos >= au_start) ? stop_pos - au_start : 64'd0,
						au_key, 1'b1);
				end
				clear_stream();
			end else begin
				pos = bump(p);
			end
		endfunction

		function int pending();
			return pending_units.size();
		endfunction

		function void report(string name, bit [63:0] want, bit [63:0] got);
			if (want != got && errors < 40) begin
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_unit(au_item_t got);
			au_item_t want;
			if (pending_units.size() == 0) begin
				if (errors < 40) begin
					$display("%0t: unexpected item expected none actual %h", $time, got);
				end
				errors++;
				return;
			end
			want = pending_units.pop_front();
			if (want != got) begin
				report("unit_offset", 64'(want.unit_offset), 64'(got.unit_offset));
				report("unit_size", 64'(want.unit_size), 64'(got.unit_size));
				report("key_unit", 64'(want.key_unit), 64'(got.key_unit));
				report("timestamp_us", want.timestamp_us, got.timestamp_us);
				report("final_unit", 64'(want.final_unit), 64'(got.final_unit));
				errors++;
			end
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [7:0]                       s_axis_tdata;
	logic                             s_axis_tlast;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	logic [127:0]                     m_axis_tdata;
	logic                             m_axis_tuser;
	logic                             m_axis_tlast;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic                             cfg_index;
	logic [annexb_pkg::STEP_BITS-1:0] cfg_data;

	au_scoreboard sb;
	bit [7:0]     stream_bytes[$];
	bit           gaps_on;
	int           burst_left;

	annexb_access_unit_splitter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	// entered and left at a falling edge
	task automatic send_byte(bit [7:0] b, bit eos);
		if (gaps_on && burst_left == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = b;
		s_axis_tlast = eos;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_byte(b, eos);
		if (burst_left > 0) begin
			burst_left--;
		end
		@(negedge clk);
	endtask

	task automatic send_stream();
		foreach (stream_bytes[i]) begin
			send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
		end
	endtask

	task automatic write_cfg(bit idx, bit [annexb_pkg::STEP_BITS-1:0] v);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic bit [7:0] pick_header(bit h265);
		int        r;
		bit [5:0]  t;
		bit [7:0]  h;
		r = $urandom_range(0, 9);
		h = 8'($urandom);
		if (h265) begin
			if (r < 3) begin
				t = 6'($urandom_range(H265_IRAP_FIRST, H265_IRAP_LAST));
			end else if (r < 6) begin
				t = $urandom_range(0, 1) ? 6'($urandom_range(0, H265_IRAP_FIRST - 1))
					: 6'($urandom_range(H265_IRAP_LAST + 1, H265_VCL_LAST));
			end else begin
				t = 6'($urandom_range(H265_VCL_LAST + 1, 63));
			end
			h[6:1] = t;
		end else begin
			if (r < 3) begin
				t = 6'(H264_IDR);
			end else if (r < 6) begin
				t = 6'($urandom_range(H264_VCL_FIRST, H264_IDR - 1));
			end else if (r < 9) begin
				t = 6'($urandom_range(H264_IDR + 1, 31));
			end else begin
				t = 6'd0;
			end
			h[4:0] = t[4:0];
		end
		return h;
	endfunction

	// well-formed NAL sequence; broken streams get random bytes overwritten
	task automatic make_nal_stream(bit broken);
		int nals, zeros, plen, r;
		stream_bytes.delete();
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) stream_bytes.push_back(8'($urandom_range(2, 255)));
		end
		nals = $urandom_range(1, 6);
		repeat (nals) begin
			r = $urandom_range(0, 9);
			zeros = (r < 7) ? 2 : (r < 9) ? 3 : $urandom_range(4, 5);
			repeat (zeros) stream_bytes.push_back(annexb_pkg::BYTE_ZERO);
			stream_bytes.push_back(annexb_pkg::BYTE_ONE);
			if ($urandom_range(0, 9) != 0) begin
				stream_bytes.push_back(pick_header(sb.codec_h265));
			end
			plen = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
			repeat (plen) begin
				stream_bytes.push_back(($urandom_range(0, 4) == 0) ? 8'h00
					: 8'($urandom_range(0, 255)));
			end
		end
		if (broken) begin
			foreach (stream_bytes[i]) begin
				if ($urandom_range(0, 7) == 0) begin
					stream_bytes[i] = 8'($urandom_range(0, 255));
				end
			end
		end
	endtask

	task automatic make_noise_stream();
		int r;
		stream_bytes.delete();
		repeat ($urandom_range(1, 40)) begin
			r = $urandom_range(0, 3);
			stream_bytes.push_back((r < 2) ? 8'h00 : (r == 2) ? 8'h01
				: 8'($urandom_range(0, 255)));
		end
	endtask

	function automatic bit [annexb_pkg::STEP_BITS-1:0] phase_step(int ph);
		case (ph % 6)
			0: return 20'd1;
			1: return 20'd1000000;
			2: return 20'd0;
			3: return 20'hFFFFF;
			default: return annexb_pkg::STEP_BITS'($urandom_range(1, 1000000));
		endcase
	endfunction

	// receiver: ready pattern changes between runs of random length, with long hold-offs
	// that start while the sender is offering bytes
	initial begin
		int mode, len, k, rx_cycles, holds;
		m_axis_tready = 1'b0;
		holds = 0;
		rx_cycles = 0;
		@(posedge arst_n);
		forever begin
			if (holds < 3 && rx_cycles > 600 * (holds + 1) && s_axis_tvalid) begin
				holds++;
				repeat (400) begin
					@(negedge clk);
					m_axis_tready = 1'b0;
				end
			end
			mode = $urandom_range(0, 4);
			len = (mode == 4) ? $urandom_range(60, 150) : $urandom_range(20, 200);
			for (k = 0; k < len; k++) begin
				@(negedge clk);
				case (mode)
					0: m_axis_tready = 1'b1;
					1: m_axis_tready = 1'($urandom_range(0, 1));
					2: m_axis_tready = (k % 4) != 0;
					3: m_axis_tready = ($urandom_range(0, 7) == 0);
					default: m_axis_tready = 1'b0;
				endcase
			end
			rx_cycles += len;
		end
	end

	always @(posedge clk) begin
		au_item_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.unit_offset = m_axis_tdata[31:0];
			got.unit_size = m_axis_tdata[63:32];
			got.timestamp_us = m_axis_tdata[127:64];
			got.key_unit = m_axis_tuser;
			got.final_unit = m_axis_tlast;
			sb.check_unit(got);
		end
	end

	initial begin
		int random_bytes, phase_count, ph, kind;
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		s_axis_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		gaps_on = 1'b1;
		burst_left = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset defaults: 4-byte code, IDR, empty NAL, VCL closing a unit, final 3-byte code
		stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h01,
			8'h00, 8'h00, 8'h01, 8'h41, 8'hAA, 8'h00, 8'h00, 8'h01};
		send_stream();
		// no start code at all
		stream_bytes = '{8'hFF, 8'h00};
		send_stream();
		// SEI only, then a 4-byte code on the final byte: no VCL, nothing out
		stream_bytes = '{8'h00, 8'h00, 8'h01, 8'h06, 8'h00, 8'h00, 8'h00, 8'h01};
		send_stream();

		random_bytes = 0;
		ph = 0;
		while (random_bytes < RANDOM_BYTES) begin
			drain();
			write_cfg(annexb_pkg::CFG_CODEC, (ph < 2) ? annexb_pkg::STEP_BITS'(ph % 2)
				: annexb_pkg::STEP_BITS'($urandom_range(0, 1)));
			write_cfg(annexb_pkg::CFG_PTS_STEP, phase_step(ph));
			gaps_on = (ph % 4) != 3;
			phase_count = 0;
			while (phase_count < PHASE_BYTES) begin
				kind = $urandom_range(0, 9);
				if (kind == 0) begin
					make_noise_stream();
				end else begin
					make_nal_stream(kind == 1);
				end
				send_stream();
				phase_count += stream_bytes.size();
			end
			random_bytes += phase_count;
			ph++;
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* annexb_access_unit_splitter.f */
rtl/core/annexb_pkg.sv
rtl/core/annexb_front.sv
rtl/core/annexb_fifo.sv
rtl/core/annexb_access_unit_splitter.sv
tb/sv/annexb_access_unit_splitter_tb.sv
